@@ src/kcgv_pkg.sv @@
`timescale 1ns / 1ps
// Package for the keyed cookie engine: field widths, mixing constants,
// register and operation codes, and the request record passed between stages.
// No dependencies.
package kcgv_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned WIN_W        = 32;
  localparam int unsigned SENDER_W     = 8;
  localparam int unsigned COOKIE_W     = 64;
  localparam int unsigned SENDER_SHIFT = 24;

  localparam int unsigned COOKIE_BYTES_DEFAULT = 8;

  // One quotient bit per divider stage
  localparam int unsigned DIV_STEPS = WIN_W;
  // Register stages in one finaliser lane
  localparam int unsigned MIX_LAT   = 5;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned MIX_SHR_1   = 30;
  localparam int unsigned MIX_SHR_2   = 27;
  localparam int unsigned MIX_SHR_3   = 31;

  localparam logic [KEY_W-1:0] SECRET_KEY_RESET    = '0;
  localparam logic [WIN_W-1:0] WINDOW_LENGTH_RESET = 32'd1000;

  typedef enum logic [0:0] {
    CFG_SECRET_KEY    = 1'b0,
    CFG_WINDOW_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    FUNC_GENERATE = 1'b0,
    FUNC_VERIFY   = 1'b1
  } func_t;

  typedef struct packed {
    func_t                func;
    logic [SENDER_W-1:0]  sender_id;
    logic [WIN_W-1:0]     window_index;
    logic [COOKIE_W-1:0]  candidate;
  } req_t;

endpackage

@@ src/kcgv_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, request record
// carried alongside. Depends on kcgv_pkg.
module kcgv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [kcgv_pkg::WIN_W-1:0]  dividend,
  input  logic [kcgv_pkg::WIN_W-1:0]  divisor,
  input  kcgv_pkg::req_t              in_req,
  output logic                        out_v,
  output logic [kcgv_pkg::WIN_W-1:0]  quotient,
  output kcgv_pkg::req_t              out_req
);

  localparam int unsigned W = kcgv_pkg::WIN_W;
  localparam int unsigned N = kcgv_pkg::DIV_STEPS;

  logic                 sv   [0:N-1];
  logic [W-1:0]         srem [0:N-1];
  logic [W-1:0]         snq  [0:N-1];
  kcgv_pkg::req_t       sreq [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic           pv;
    logic [W-1:0]   prem;
    logic [W-1:0]   pnq;
    kcgv_pkg::req_t preq;
    logic [W:0]     trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign pv   = in_v;
      assign prem = '0;
      assign pnq  = dividend;
      assign preq = in_req;
    end else begin : g_rest
      assign pv   = sv[k-1];
      assign prem = srem[k-1];
      assign pnq  = snq[k-1];
      assign preq = sreq[k-1];
    end

    // Shift in the next dividend bit and try the subtraction
    assign trial = {prem, pnq[W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem[k] <= ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
        snq[k]  <= {pnq[W-2:0], ge};
        sreq[k] <= preq;
      end
    end
  end

  assign out_v    = sv[N-1];
  assign quotient = snq[N-1];
  assign out_req  = sreq[N-1];

endmodule

@@ src/kcgv_mix.sv @@
`timescale 1ns / 1ps
// Five-stage 64-bit finaliser lane: add, xor-shift, two split multiplies.
// Depends on kcgv_pkg.
module kcgv_mix (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] z_in,
  output logic [63:0] z_out
);

  localparam logic [31:0] A_LO = kcgv_pkg::MIX_MUL_A[31:0];
  localparam logic [31:0] A_HI = kcgv_pkg::MIX_MUL_A[63:32];
  localparam logic [31:0] B_LO = kcgv_pkg::MIX_MUL_B[31:0];
  localparam logic [31:0] B_HI = kcgv_pkg::MIX_MUL_B[63:32];

  logic [63:0] z_add;
  logic [63:0] x1;
  logic [63:0] pa_ll;
  logic [31:0] pa_lh;
  logic [31:0] pa_hl;
  logic [63:0] y;
  logic [63:0] x2;
  logic [63:0] pb_ll;
  logic [31:0] pb_lh;
  logic [31:0] pb_hl;
  logic [63:0] z;

  assign z_add = z_in + kcgv_pkg::GOLDEN_STEP;
  // Low 64 bits of a 64x64 product: full low partial plus the two cross terms
  assign y     = pa_ll + {32'(pa_lh + pa_hl), 32'h0};
  assign z     = pb_ll + {32'(pb_lh + pb_hl), 32'h0};

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= z_add ^ (z_add >> kcgv_pkg::MIX_SHR_1);
      pa_ll <= 64'(x1[31:0]) * 64'(A_LO);
      pa_lh <= 32'(x1[31:0] * A_HI);
      pa_hl <= 32'(x1[63:32] * A_LO);
      x2    <= y ^ (y >> kcgv_pkg::MIX_SHR_2);
      pb_ll <= 64'(x2[31:0]) * 64'(B_LO);
      pb_lh <= 32'(x2[31:0] * B_HI);
      pb_hl <= 32'(x2[63:32] * B_LO);
      z_out <= z ^ (z >> kcgv_pkg::MIX_SHR_3);
    end
  end

endmodule

@@ src/keyed_cookie_generate_verify.sv @@
`timescale 1ns / 1ps
// Keyed cookie engine, generate and verify. A request passes 32 divider
// stages, 5 finaliser stages, then the compare and output registers to reach
// out_valid. Throughput: one request per cycle while in_stall is low, set by
// the fully pipelined divider and two parallel finaliser lanes. Synchronous
// reset clears all valid bits and loads secret_key = 0, window_length_ms = 1000.
module keyed_cookie_generate_verify #(
  parameter int unsigned COOKIE_BYTES = kcgv_pkg::COOKIE_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [kcgv_pkg::SENDER_W-1:0]   sender_id,
  input  logic [kcgv_pkg::WIN_W-1:0]      window_index,
  input  logic [kcgv_pkg::WIN_W-1:0]      now_ms,
  input  logic [kcgv_pkg::COOKIE_W-1:0]   candidate_cookie,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kcgv_pkg::COOKIE_W-1:0]   cookie_value,
  output logic                            match,
  // Configuration write port
  input  logic                            cfg_write,
  input  logic [0:0]                      cfg_index,
  input  logic [kcgv_pkg::WIN_W-1:0]      cfg_data
);

  // Cookie keeps only its low COOKIE_BYTES bytes
  localparam logic [63:0] COOKIE_MASK =
    (COOKIE_BYTES >= 8) ? '1 : ((64'd1 << (8 * COOKIE_BYTES)) - 64'd1);

  typedef struct packed {
    kcgv_pkg::func_t func;
    logic            has_prev;
    logic [63:0]     candidate;
  } tag_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [kcgv_pkg::KEY_W-1:0] secret_key;
  logic [kcgv_pkg::WIN_W-1:0] window_length_ms;
  logic [kcgv_pkg::WIN_W-1:0] divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      secret_key       <= kcgv_pkg::SECRET_KEY_RESET;
      window_length_ms <= kcgv_pkg::WINDOW_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (kcgv_pkg::cfg_reg_t'(cfg_index))
        kcgv_pkg::CFG_SECRET_KEY:    secret_key       <= cfg_data;
        kcgv_pkg::CFG_WINDOW_LENGTH: window_length_ms <= cfg_data;
      endcase
    end
  end

  // A zero window length behaves as one millisecond
  assign divisor = (window_length_ms == '0) ? kcgv_pkg::WIN_W'(1) : window_length_ms;

  // ---------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless the skid slot is taken,
  // so a result waiting at the output never blocks new requests on its own.
  // ---------------------------------------------------------------------
  logic advance;
  logic skid_valid;

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;

  // ---------------------------------------------------------------------
  // Stage group 1: window = now_ms / window_length, one bit per stage.
  // Generate requests ride through too, so every request sees one latency.
  // ---------------------------------------------------------------------
  kcgv_pkg::req_t in_req;
  logic           div_v;
  logic [31:0]    quotient;
  kcgv_pkg::req_t div_req;

  assign in_req.func         = kcgv_pkg::func_t'(func);
  assign in_req.sender_id    = sender_id;
  assign in_req.window_index = window_index;
  assign in_req.candidate    = candidate_cookie & COOKIE_MASK;

  kcgv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_v     (in_valid && !in_stall),
    .dividend (now_ms),
    .divisor  (divisor),
    .in_req   (in_req),
    .out_v    (div_v),
    .quotient (quotient),
    .out_req  (div_req)
  );

  // ---------------------------------------------------------------------
  // Stage group 2: build the key word for the current window (window_index
  // on generate) and the one before, and mix both in parallel finaliser lanes.
  // ---------------------------------------------------------------------
  logic [31:0] win_cur;
  logic [31:0] win_prev;
  logic [31:0] sender_word;
  logic [63:0] word_cur;
  logic [63:0] word_prev;
  logic [63:0] mix_cur;
  logic [63:0] mix_prev;
  tag_t        div_tag;

  assign win_cur     = (div_req.func == kcgv_pkg::FUNC_VERIFY) ? quotient
                                                               : div_req.window_index;
  assign win_prev    = quotient - 32'd1;
  assign sender_word = 32'(div_req.sender_id) << kcgv_pkg::SENDER_SHIFT;
  assign word_cur    = {secret_key, win_cur ^ sender_word};
  assign word_prev   = {secret_key, win_prev ^ sender_word};

  // Previous window is checked only on verify, and only above window zero
  assign div_tag.func      = div_req.func;
  assign div_tag.has_prev  = (div_req.func == kcgv_pkg::FUNC_VERIFY) && (quotient != '0);
  assign div_tag.candidate = div_req.candidate;

  kcgv_mix u_mix_cur (
    .clk   (clk),
    .en    (advance),
    .z_in  (word_cur),
    .z_out (mix_cur)
  );

  kcgv_mix u_mix_prev (
    .clk   (clk),
    .en    (advance),
    .z_in  (word_prev),
    .z_out (mix_prev)
  );

  // Valid bits and request tags travel beside the mixing lanes
  logic mv   [0:kcgv_pkg::MIX_LAT-1];
  tag_t mtag [0:kcgv_pkg::MIX_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kcgv_pkg::MIX_LAT; i++) begin
        mv[i] <= 1'b0;
      end
    end else if (advance) begin
      mv[0] <= div_v;
      for (int i = 1; i < kcgv_pkg::MIX_LAT; i++) begin
        mv[i] <= mv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mtag[0] <= div_tag;
      for (int i = 1; i < kcgv_pkg::MIX_LAT; i++) begin
        mtag[i] <= mtag[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage group 3: truncate, compare and register the result.
  // ---------------------------------------------------------------------
  localparam int unsigned LAST = kcgv_pkg::MIX_LAT - 1;

  logic [63:0] cookie_cur;
  logic [63:0] cookie_prev;
  logic        hit;
  logic        res_valid;
  logic [63:0] res_cookie;
  logic        res_match;

  assign cookie_cur  = mix_cur & COOKIE_MASK;
  assign cookie_prev = mix_prev & COOKIE_MASK;
  assign hit = (cookie_cur == mtag[LAST].candidate) ||
               (mtag[LAST].has_prev && (cookie_prev == mtag[LAST].candidate));

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= mv[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (mtag[LAST].func == kcgv_pkg::FUNC_VERIFY) begin
        res_cookie <= '0;
        res_match  <= hit;
      end else begin
        res_cookie <= cookie_cur;
        res_match  <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register plus one skid slot. When the output is stalled the
  // pipe still drains one result into the skid slot; only then does it
  // hold and raise in_stall.
  // ---------------------------------------------------------------------
  logic        out_free;
  logic [63:0] skid_cookie;
  logic        skid_match;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        cookie_value <= skid_cookie;
        match        <= skid_match;
      end else begin
        cookie_value <= res_cookie;
        match        <= res_match;
      end
    end else if (!skid_valid) begin
      skid_cookie <= res_cookie;
      skid_match  <= res_match;
    end
  end

endmodule
